// ===== sv/rgb_histogram_normalized_assert.svh =====
// Assertion macros shared by the histogram modules.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef RGB_HISTOGRAM_NORMALIZED_ASSERT_SVH
`define RGB_HISTOGRAM_NORMALIZED_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHN_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rhn: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RHN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rhn: next-cycle check failed");

`endif

// ===== sv/rhn_pkg.sv =====
package rhn_pkg;

    // Default sizing of the counters and of the share fraction.
    localparam int CNT_BITS_DEF  = 22;
    localparam int FRAC_BITS_DEF = 16;

    // Bin store geometry.
    localparam int BIN_COUNT = 256;
    localparam int BIN_W     = $clog2(BIN_COUNT);

    // Result field widths.
    localparam int SHARE_W = 17;
    localparam int ALL_W   = 18;
    localparam int TOTAL_W = 22;

    // Divider lanes: one per channel and one for the channel sum.
    localparam int LANES     = 4;
    localparam int LANE_RED  = 0;
    localparam int LANE_GRN  = 1;
    localparam int LANE_BLU  = 2;
    localparam int LANE_ALL  = 3;

    // Operation codes of an input transfer.
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } rhn_op_t;

    typedef struct packed {
        logic [1:0]       operation;
        logic [BIN_W-1:0] red;
        logic [BIN_W-1:0] green;
        logic [BIN_W-1:0] blue;
        logic [BIN_W-1:0] bin_index;
    } rhn_in_t;

    typedef struct packed {
        logic [BIN_W-1:0]   bin_read;
        logic [SHARE_W-1:0] red_share;
        logic [SHARE_W-1:0] green_share;
        logic [SHARE_W-1:0] blue_share;
        logic [ALL_W-1:0]   all_share;
        logic [TOTAL_W-1:0] pixel_total;
        logic               saturated;
    } rhn_out_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD_WR,
        ST_RD_WAIT,
        ST_DIV
    } rhn_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic pix_read;
        logic bin_read;
        logic bin_write;
        logic clear;
        logic set_ovf;
        logic div_start;
        logic load_out;
    } rhn_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_limit;
        logic div_busy;
    } rhn_stat_t;

endpackage

// ===== sv/rhn_bin_mem.sv =====
module rhn_bin_mem #(
    parameter int COUNT_BITS = rhn_pkg::CNT_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      clear,
    input  logic                      rd_en,
    input  logic [rhn_pkg::BIN_W-1:0] rd_addr,
    input  logic                      wr_en,
    input  logic [rhn_pkg::BIN_W-1:0] wr_addr,
    input  logic [COUNT_BITS-1:0]     wr_data,
    output logic [COUNT_BITS-1:0]     rd_count
);
    import rhn_pkg::*;

    logic [COUNT_BITS-1:0] count_mem_reg [BIN_COUNT];
    logic [BIN_COUNT-1:0]  valid_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_valid_reg;

    // Count memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            count_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= count_mem_reg[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Valid bits: a bin that was never written since the last clear reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clear) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_count = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== sv/rhn_divider.sv =====
module rhn_divider #(
    parameter int COUNT_BITS    = rhn_pkg::CNT_BITS_DEF,
    parameter int FRACTION_BITS = rhn_pkg::FRAC_BITS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         start,
    input  logic [COUNT_BITS-1:0]                        divisor,
    input  logic [rhn_pkg::LANES-1:0][COUNT_BITS+1:0]    numer,
    output logic                                         busy,
    output logic [rhn_pkg::LANES-1:0][FRACTION_BITS+1:0] quotient
);
    import rhn_pkg::*;

    localparam int QUO_W  = FRACTION_BITS + 2;
    localparam int NUM_W  = COUNT_BITS + 2;
    localparam int STEP_W = $clog2(QUO_W);

    logic [COUNT_BITS-1:0]             dsr_reg;
    logic [LANES-1:0][COUNT_BITS-1:0]  rem_reg;
    logic [LANES-1:0][COUNT_BITS-1:0]  rem_next;
    logic [LANES-1:0][QUO_W-1:0]       sh_reg;
    logic [LANES-1:0][QUO_W-1:0]       sh_next;
    logic [LANES-1:0][COUNT_BITS:0]    trial;
    logic [LANES-1:0]                  fits;
    logic [STEP_W-1:0]                 step_reg;
    logic [STEP_W-1:0]                 step_next;
    logic                              busy_reg;
    logic                              busy_next;

    // One restoring step per cycle in every lane. The shift register holds the
    // dividend bits still to come at its top and collects quotient bits at its
    // bottom. Since every numerator is at most three times the divisor, the
    // quotient fits in FRACTION_BITS + 2 bits and the remainder starts as the
    // numerator without its two lowest bits.
    always_comb begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        for (int l = 0; l < LANES; l++) begin
            trial[l] = {rem_reg[l], sh_reg[l][QUO_W-1]};
            fits[l]  = trial[l] >= {1'b0, dsr_reg};
        end
        if (start) begin
            for (int l = 0; l < LANES; l++) begin
                rem_next[l] = numer[l][NUM_W-1:2];
                sh_next[l]  = {numer[l][1:0], {FRACTION_BITS{1'b0}}};
            end
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            for (int l = 0; l < LANES; l++) begin
                rem_next[l] = fits[l] ? COUNT_BITS'(trial[l] - {1'b0, dsr_reg})
                                      : trial[l][COUNT_BITS-1:0];
                sh_next[l]  = {sh_reg[l][QUO_W-2:0], fits[l]};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(QUO_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            dsr_reg <= divisor;
        end
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign busy     = busy_reg;
    assign quotient = sh_reg;

endmodule

// ===== sv/rhn_datapath.sv =====
`include "rgb_histogram_normalized_assert.svh"

module rhn_datapath #(
    parameter int COUNT_BITS    = rhn_pkg::CNT_BITS_DEF,
    parameter int FRACTION_BITS = rhn_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rhn_pkg::rhn_in_t  s_data,
    input  rhn_pkg::rhn_cmd_t cmd,
    output rhn_pkg::rhn_stat_t status,
    output rhn_pkg::rhn_out_t m_data
);
    import rhn_pkg::*;

    localparam int NUM_W = COUNT_BITS + 2;
    localparam int QUO_W = FRACTION_BITS + 2;

    logic [COUNT_BITS-1:0]            total_reg;
    logic                             ovf_reg;
    logic [BIN_W-1:0]                 idx_reg;
    logic [BIN_W-1:0]                 red_addr_reg;
    logic [BIN_W-1:0]                 green_addr_reg;
    logic [BIN_W-1:0]                 blue_addr_reg;
    rhn_out_t                         out_reg;
    logic                             mem_rd_en;
    logic [BIN_W-1:0]                 red_rd_addr;
    logic [BIN_W-1:0]                 green_rd_addr;
    logic [BIN_W-1:0]                 blue_rd_addr;
    logic [COUNT_BITS-1:0]            red_count;
    logic [COUNT_BITS-1:0]            green_count;
    logic [COUNT_BITS-1:0]            blue_count;
    logic [LANES-1:0][NUM_W-1:0]      numer;
    logic [LANES-1:0][QUO_W-1:0]      quotient;
    logic                             div_busy;
    logic                             total_zero;

    // Read addresses: the pixel's channels for an add, the named bin for a read.
    assign mem_rd_en     = cmd.pix_read | cmd.bin_read;
    assign red_rd_addr   = cmd.pix_read ? s_data.red   : s_data.bin_index;
    assign green_rd_addr = cmd.pix_read ? s_data.green : s_data.bin_index;
    assign blue_rd_addr  = cmd.pix_read ? s_data.blue  : s_data.bin_index;

    rhn_bin_mem #(.COUNT_BITS(COUNT_BITS)) u_red_bins (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (cmd.clear),
        .rd_en    (mem_rd_en),
        .rd_addr  (red_rd_addr),
        .wr_en    (cmd.bin_write),
        .wr_addr  (red_addr_reg),
        .wr_data  (red_count + COUNT_BITS'(1)),
        .rd_count (red_count)
    );

    rhn_bin_mem #(.COUNT_BITS(COUNT_BITS)) u_green_bins (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (cmd.clear),
        .rd_en    (mem_rd_en),
        .rd_addr  (green_rd_addr),
        .wr_en    (cmd.bin_write),
        .wr_addr  (green_addr_reg),
        .wr_data  (green_count + COUNT_BITS'(1)),
        .rd_count (green_count)
    );

    rhn_bin_mem #(.COUNT_BITS(COUNT_BITS)) u_blue_bins (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (cmd.clear),
        .rd_en    (mem_rd_en),
        .rd_addr  (blue_rd_addr),
        .wr_en    (cmd.bin_write),
        .wr_addr  (blue_addr_reg),
        .wr_data  (blue_count + COUNT_BITS'(1)),
        .rd_count (blue_count)
    );

    // Divider numerators: the three bin counts and their sum.
    assign numer[LANE_RED] = NUM_W'(red_count);
    assign numer[LANE_GRN] = NUM_W'(green_count);
    assign numer[LANE_BLU] = NUM_W'(blue_count);
    assign numer[LANE_ALL] = NUM_W'(red_count) + NUM_W'(green_count) + NUM_W'(blue_count);

    rhn_divider #(
        .COUNT_BITS    (COUNT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .divisor  (total_reg),
        .numer    (numer),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Pixel total and saturation flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.clear) begin
            total_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            if (cmd.bin_write) begin
                total_reg <= total_reg + COUNT_BITS'(1);
            end
            if (cmd.set_ovf) begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Item capture, kept for the write-back of an add and for the result of a read.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            idx_reg        <= s_data.bin_index;
            red_addr_reg   <= s_data.red;
            green_addr_reg <= s_data.green;
            blue_addr_reg  <= s_data.blue;
        end
    end

    // Result register; an empty image reads as zero shares.
    assign total_zero = (total_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.bin_read    <= idx_reg;
            out_reg.red_share   <= total_zero ? '0 : SHARE_W'(quotient[LANE_RED]);
            out_reg.green_share <= total_zero ? '0 : SHARE_W'(quotient[LANE_GRN]);
            out_reg.blue_share  <= total_zero ? '0 : SHARE_W'(quotient[LANE_BLU]);
            out_reg.all_share   <= total_zero ? '0 : ALL_W'(quotient[LANE_ALL]);
            out_reg.pixel_total <= TOTAL_W'(total_reg);
            out_reg.saturated   <= ovf_reg;
        end
    end

    assign m_data          = out_reg;
    assign status.at_limit = &total_reg;
    assign status.div_busy = div_busy;

    // The total moves only on a bin write or a clear.
    `RHN_ASSERT_NEXT(a_total_steady, !cmd.clear && !cmd.bin_write, total_reg == $past(total_reg))
    // A bin write always leaves a non-empty image behind.
    `RHN_ASSERT_NEXT(a_total_after_write, cmd.bin_write, total_reg != '0)

endmodule

// ===== sv/rhn_ctrl.sv =====
`include "rgb_histogram_normalized_assert.svh"

module rhn_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         operation,
    input  rhn_pkg::rhn_stat_t status,
    output rhn_pkg::rhn_cmd_t  cmd,
    output logic               m_valid,
    input  logic               m_ready
);
    import rhn_pkg::*;

    rhn_state_t state_reg;
    rhn_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    // State and result-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    case (operation)
                        OP_ADD: begin
                            if (status.at_limit) begin
                                cmd.set_ovf = 1'b1;
                            end else begin
                                cmd.pix_read = 1'b1;
                                state_next   = ST_ADD_WR;
                            end
                        end
                        OP_READ: begin
                            cmd.bin_read = 1'b1;
                            state_next   = ST_RD_WAIT;
                        end
                        OP_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADD_WR: begin
                cmd.bin_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_RD_WAIT: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                // Hand the result over once the divider is done and the slot is free.
                if (!status.div_busy && (!m_valid_reg || m_ready)) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    // The divider is running in the cycle after it was started.
    `RHN_ASSERT_NEXT(a_div_started, state_reg == ST_RD_WAIT, status.div_busy)
    // Bin write-back happens only while the total is below its limit.
    `RHN_ASSERT_IMPLIES(a_write_below_limit, state_reg == ST_ADD_WR, !status.at_limit)
    // A finished read waits while the previous result is still held.
    `RHN_ASSERT_NEXT(a_read_waits, state_reg == ST_DIV && m_valid_reg && !m_ready, state_reg == ST_DIV)

endmodule

// ===== sv/rgb_histogram_normalized.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  rhn_in_t: operation, red, green, blue, bin_index
// m_        out        m_valid / m_ready  rhn_out_t: bin_read, shares, pixel_total, saturated
//
// An add does a registered read of the three bin memories, then write-back.
// A dropped add, a clear and an unused code are handled without leaving the idle state; a clear resets the valid bits.
// A read waits for the divider, which retires one quotient bit a cycle.
// Reset is synchronous and active low and leaves every bin, the total and the flag at zero.
// A finished result waits in the output register; while it is held, new items are still
// accepted, and only the next read stalls before handing over its result.
module rgb_histogram_normalized #(
    parameter int COUNT_BITS    = rhn_pkg::CNT_BITS_DEF,
    parameter int FRACTION_BITS = rhn_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rhn_pkg::rhn_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rhn_pkg::rhn_out_t m_data
);
    import rhn_pkg::*;

    rhn_cmd_t  cmd;
    rhn_stat_t status;

    rhn_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .operation (s_data.operation),
        .status    (status),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

    rhn_datapath #(
        .COUNT_BITS    (COUNT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

endmodule

// ===== dv/rgb_histogram_normalized_tb.sv =====
`timescale 1ns / 1ps

module rgb_histogram_normalized_tb;

    import rhn_pkg::*;

    // The block is built with its default counter and fraction sizing.
    localparam int TB_COUNT_BITS    = CNT_BITS_DEF;
    localparam int TB_FRACTION_BITS = FRAC_BITS_DEF;
    localparam longint unsigned COUNT_LIMIT = (64'd1 << TB_COUNT_BITS) - 1;

    // Operation code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int HOLD_CYCLES       = 300;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int DRAIN_CYCLES      = 2 * (TB_FRACTION_BITS + 5);
    localparam int LONG_FRAME_PIXELS = 200;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rhn_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rhn_out_t m_data;

    // Shadow histogram kept by the testbench.
    logic [TB_COUNT_BITS-1:0] red_hist   [BIN_COUNT];
    logic [TB_COUNT_BITS-1:0] green_hist [BIN_COUNT];
    logic [TB_COUNT_BITS-1:0] blue_hist  [BIN_COUNT];
    logic [TB_COUNT_BITS-1:0] pixels_seen;
    logic                     drop_seen;

    rhn_out_t pending_shares [$];

    int unsigned errors         = 0;
    int unsigned items_sent     = 0;
    int unsigned shares_checked = 0;
    int unsigned saturated_seen = 0;
    int unsigned input_stalls   = 0;

    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit hold_request = 1'b0;
    bit rx_holding   = 1'b0;

    rgb_histogram_normalized #(
        .COUNT_BITS    (TB_COUNT_BITS),
        .FRACTION_BITS (TB_FRACTION_BITS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_histogram();
        for (int i = 0; i < BIN_COUNT; i++) begin
            red_hist[i]   = '0;
            green_hist[i] = '0;
            blue_hist[i]  = '0;
        end
        pixels_seen = '0;
        drop_seen   = 1'b0;
    endfunction

    // Count over total in fixed point, truncated; an empty image gives zero.
    function automatic longint unsigned fixed_share(longint unsigned count,
                                                    longint unsigned total);
        if (total == 0)
            return 0;
        return (count << TB_FRACTION_BITS) / total;
    endfunction

    // Applies one accepted transfer to the shadow histogram and queues any read result.
    function automatic void histogram_apply(rhn_in_t item);
        rhn_out_t        res;
        longint unsigned rc;
        longint unsigned gc;
        longint unsigned bc;
        longint unsigned total;
        case (item.operation)
            OP_ADD: begin
                if (pixels_seen == COUNT_LIMIT) begin
                    drop_seen = 1'b1;
                end else begin
                    red_hist[item.red]     += 1'b1;
                    green_hist[item.green] += 1'b1;
                    blue_hist[item.blue]   += 1'b1;
                    pixels_seen            += 1'b1;
                end
            end
            OP_READ: begin
                rc    = red_hist[item.bin_index];
                gc    = green_hist[item.bin_index];
                bc    = blue_hist[item.bin_index];
                total = pixels_seen;
                res.bin_read    = item.bin_index;
                res.red_share   = SHARE_W'(fixed_share(rc, total));
                res.green_share = SHARE_W'(fixed_share(gc, total));
                res.blue_share  = SHARE_W'(fixed_share(bc, total));
                res.all_share   = ALL_W'(fixed_share(rc + gc + bc, total));
                res.pixel_total = TOTAL_W'(total);
                res.saturated   = drop_seen;
                pending_shares.push_back(res);
            end
            OP_CLEAR: begin
                clear_histogram();
            end
            default: begin
            end
        endcase
    endfunction

    // Every accepted input transfer updates the shadow histogram in order.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            histogram_apply(s_data);
        if (aresetn && s_valid && !s_ready)
            input_stalls++;
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Each result transfer is compared with the oldest pending read.
    always @(posedge aclk) begin : check_results
        rhn_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_shares.size() == 0) begin
                $error("result for bin %0d arrived with no read pending", m_data.bin_read);
                errors++;
            end else begin
                want = pending_shares.pop_front();
                check_field("bin_read", want.bin_read, m_data.bin_read);
                check_field("red_share", want.red_share, m_data.red_share);
                check_field("green_share", want.green_share, m_data.green_share);
                check_field("blue_share", want.blue_share, m_data.blue_share);
                check_field("all_share", want.all_share, m_data.all_share);
                check_field("pixel_total", want.pixel_total, m_data.pixel_total);
                check_field("saturated", want.saturated, m_data.saturated);
                shares_checked++;
                if (want.saturated)
                    saturated_seen++;
            end
        end
    end

    // Result side: random ready bursts and stalls, or a long hold-off when asked for.
    initial begin : receiver
        int unsigned burst;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                rx_holding = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_holding   = 1'b0;
                hold_request = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                burst = $urandom_range(1, 16);
                repeat (burst) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                burst = rx_idle_on ? $urandom_range(1, 16) : 1;
                repeat (burst) @(posedge aclk);
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog expired with %0d reads outstanding.", pending_shares.size());
        $display("rgb_histogram_normalized test failed");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic rhn_in_t make_item(logic [1:0] op, logic [7:0] r, logic [7:0] g,
                                          logic [7:0] b, logic [7:0] idx);
        rhn_in_t item;
        item.operation = op;
        item.red       = r;
        item.green     = g;
        item.blue      = b;
        item.bin_index = idx;
        return item;
    endfunction

    // Offers one item, possibly after a random idle burst, and waits for its transfer.
    task automatic drive_transfer(rhn_in_t item);
        int unsigned gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (item.operation != OP_UNUSED)
            items_sent++;
    endtask

    task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        drive_transfer(make_item(OP_ADD, r, g, b, rand_byte()));
    endtask

    task automatic read_bin(logic [7:0] idx);
        drive_transfer(make_item(OP_READ, rand_byte(), rand_byte(), rand_byte(), idx));
    endtask

    task automatic send_op(logic [1:0] op);
        drive_transfer(make_item(op, rand_byte(), rand_byte(), rand_byte(), rand_byte()));
    endtask

    // Withdraws the last item from the input and waits until every read has answered.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_shares.size() != 0) @(posedge aclk);
    endtask

    // Reads of an empty image must return zero shares; the unused code changes nothing.
    task automatic test_empty_image();
        read_bin(8'd0);
        read_bin(8'd255);
        send_op(OP_UNUSED);
        read_bin(8'h80);
        wait_for_results();
    endtask

    // Channel values at both ends, one bin shared by all channels, and a clear.
    task automatic test_channel_extremes();
        add_pixel(8'd0, 8'd0, 8'd0);
        add_pixel(8'd255, 8'd255, 8'd255);
        add_pixel(8'd0, 8'd255, 8'd0);
        add_pixel(8'd255, 8'd0, 8'd255);
        add_pixel(8'h55, 8'hAA, 8'h55);
        read_bin(8'd0);
        read_bin(8'd255);
        read_bin(8'h55);
        read_bin(8'hAA);
        add_pixel(8'd0, 8'd0, 8'd0);
        read_bin(8'd0);
        send_op(OP_UNUSED);
        read_bin(8'd0);
        send_op(OP_CLEAR);
        read_bin(8'd0);
        read_bin(8'd255);
        add_pixel(8'd1, 8'd2, 8'd3);
        read_bin(8'd2);
        wait_for_results();
    endtask

    // A long frame piles every red value and every third blue value into bin 7, then is cleared.
    task automatic test_long_frame();
        send_op(OP_CLEAR);
        for (int i = 0; i < LONG_FRAME_PIXELS; i++)
            add_pixel(8'd7, 8'(i), (i % 3 == 0) ? 8'd7 : 8'(255 - i));
        read_bin(8'd7);
        read_bin(8'd0);
        read_bin(8'd255);
        send_op(OP_CLEAR);
        read_bin(8'd7);
        add_pixel(8'd7, 8'd8, 8'd7);
        read_bin(8'd7);
        wait_for_results();
    endtask

    // The receiver holds off while reads keep coming, so the block must stall its input.
    task automatic test_backpressure();
        hold_request = 1'b1;
        while (!rx_holding) @(posedge aclk);
        for (int i = 0; i < 8; i++) begin
            add_pixel(rand_byte(), rand_byte(), rand_byte());
            read_bin(rand_byte());
        end
        wait_for_results();
    endtask

    // Frames of pixels drawn from a narrow or full palette, with reads and some noise.
    task automatic test_random_frames(int unsigned item_count);
        int unsigned sent;
        int unsigned frame_len;
        int unsigned pick;
        int unsigned span;
        logic [7:0]  base;
        sent = 0;
        while (sent < item_count) begin
            send_op(OP_CLEAR);
            sent++;
            frame_len = ($urandom_range(0, 4) == 0) ? $urandom_range(280, 420)
                                                    : $urandom_range(1, 80);
            base = rand_byte();
            span = ($urandom_range(0, 1) == 0) ? 7 : 255;
            repeat (frame_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    add_pixel(8'(base + $urandom_range(0, span)),
                              8'(base + $urandom_range(0, span)),
                              8'(base + $urandom_range(0, span)));
                    sent++;
                end else if (pick < 92) begin
                    read_bin(8'(base + $urandom_range(0, span)));
                    sent++;
                end else if (pick < 96) begin
                    send_op(OP_UNUSED);
                end else begin
                    send_op(2'($urandom_range(0, 2)));
                    sent++;
                end
            end
        end
        wait_for_results();
    endtask

    // Test sequence.
    initial begin
        clear_histogram();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_image();
        test_channel_extremes();
        test_long_frame();
        test_backpressure();
        test_random_frames(1200);

        // Last part runs with no idling on either side.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_frames(200);
        s_valid <= 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d pixel, read and clear transfers; checked %0d shares, %0d saturated.",
                 items_sent, shares_checked, saturated_seen);
        $display("The input was held back for %0d cycles in all.", input_stalls);
        if (errors == 0 && pending_shares.size() == 0) begin
            $display("rgb_histogram_normalized test passed");
        end else begin
            $display("rgb_histogram_normalized test failed");
        end
        $finish;
    end

endmodule
